FILE: src/mftt_pkg.sv
// Package with the shared types and constants of the motor feedback turn tracker.
`timescale 1ns / 1ps
`default_nettype none

package mftt_pkg;

    // Weight of one full turn in the total position word.
    localparam int TURN_SHIFT = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_ID     = 3'd1;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        logic [1:0]         slot_index;
        logic [15:0]        angle;
        logic [15:0]        speed_raw;
        logic [15:0]        current_raw;
        logic signed [31:0] turn_count;
        logic signed [31:0] total_position;
        logic [15:0]        home_angle;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    // One slot of the state memory.
    typedef struct packed {
        logic [15:0]        last_angle;
        logic signed [31:0] turns;
        logic [15:0]        latched_zero;
    } t_slot_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: src/mftt_if.sv
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface mftt_in_if;
    import mftt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mftt_out_if;
    import mftt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mftt_cfg_if;
    import mftt_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_write payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/motor_feedback_turn_tracker_top.sv
// Top level of the motor feedback turn tracker: id match, state memory and unwrapping.
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the read, update and output steps around the single-port
// state memory; its result is registered and held on the output until taken, and no new
// item is accepted before then. Reset (synchronous, active low) clears the sequencer state,
// the slot count, the slot ids and the per-slot valid bits at once; a slot that is not
// valid reads as all zero, so no clearing pass.

module motor_feedback_turn_tracker_top #(
    parameter int MOTOR_SLOTS = 4,
    parameter int ANGLE_MAX   = 8191
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mftt_in_if.sink     i_in,
    mftt_out_if.source  o_out,
    mftt_cfg_if.sink    i_cfg
);
    import mftt_pkg::*;

    localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    // Half a turn in angle counts, as a signed value wide enough for any difference.
    localparam logic signed [17:0] HALF_TURN = 18'(ANGLE_MAX / 2);

    // Configuration registers. The port never stalls.
    logic [2:0]  r_slots_in_use;
    logic [10:0] r_slot_id [MOTOR_SLOTS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= '0;
            for (int k = 0; k < MOTOR_SLOTS; k++) begin
                r_slot_id[k] <= '0;
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.payload.index == CFG_SLOTS_IN_USE) begin
                r_slots_in_use <= i_cfg.payload.data[2:0];
            end
            // Writes to ids of slots that do not exist simply find no register.
            for (int k = 0; k < MOTOR_SLOTS; k++) begin
                if (i_cfg.payload.index == CFG_IDX_W'(CFG_SLOT0_ID + k)) begin
                    r_slot_id[k] <= i_cfg.payload.data;
                end
            end
        end
    end

    // Sequencer state.
    t_state r_state, n_state;

    logic in_accept;
    logic out_accept;

    assign in_accept  = i_in.valid && i_in.ready;
    assign out_accept = o_out.valid && o_out.ready;

    // Frame id search: the lowest searched slot whose id matches wins. A slot count
    // above the number of slots simply searches every slot.
    logic              c_hit;
    logic [SLOT_W-1:0] c_hit_slot;

    always_comb begin
        c_hit      = 1'b0;
        c_hit_slot = '0;
        for (int s = MOTOR_SLOTS - 1; s >= 0; s--) begin
            if ((32'(s) < 32'(r_slots_in_use)) && (r_slot_id[s] == i_in.payload.frame_id)) begin
                c_hit      = 1'b1;
                c_hit_slot = SLOT_W'(s);
            end
        end
    end

    // Item registers, loaded on acceptance.
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [15:0]       r_angle;
    logic [15:0]       r_speed;
    logic [15:0]       r_current;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hit     <= c_hit;
            r_slot    <= c_hit_slot;
            r_angle   <= {i_in.payload.byte0, i_in.payload.byte1};
            r_speed   <= {i_in.payload.byte2, i_in.payload.byte3};
            r_current <= {i_in.payload.byte4, i_in.payload.byte5};
        end
    end

    // Per-slot state memory with a registered read. The valid bit of a slot doubles as
    // its zero-captured flag: a slot is only ever written when a frame matches it, and
    // that first write is also the one that latches the zero angle.
    t_slot_entry r_mem [MOTOR_SLOTS];
    logic [MOTOR_SLOTS-1:0] r_slot_valid;
    t_slot_entry r_rd_data;
    logic        r_rd_valid;
    logic        c_wr_en;
    t_slot_entry c_wr_data;

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data  <= r_mem[r_slot];
            r_rd_valid <= r_slot_valid[r_slot];
        end
        if (c_wr_en) begin
            r_mem[r_slot] <= c_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (c_wr_en) begin
            r_slot_valid[r_slot] <= 1'b1;
        end
    end

    // Unwrapping on the entry just read. A slot never written behaves as all zero.
    t_slot_entry       c_old;
    logic signed [17:0] c_diff;
    logic signed [31:0] c_turns;
    logic signed [31:0] c_pos;
    logic [15:0]        c_zero;

    always_comb begin
        c_old  = r_rd_valid ? r_rd_data : '0;
        c_diff = $signed({2'b00, c_old.last_angle}) - $signed({2'b00, r_angle});
        if (c_diff > HALF_TURN) begin
            c_turns = c_old.turns + 32'sd1;
        end else if (c_diff < -HALF_TURN) begin
            c_turns = c_old.turns - 32'sd1;
        end else begin
            c_turns = c_old.turns;
        end
        c_pos  = (c_turns <<< TURN_SHIFT) + $signed({16'd0, r_angle});
        c_zero = r_rd_valid ? c_old.latched_zero : r_angle;

        c_wr_data.last_angle   = r_angle;
        c_wr_data.turns        = c_turns;
        c_wr_data.latched_zero = c_zero;
    end

    // Result register. An unmatched frame gives an all-zero result.
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            if (r_hit) begin
                r_out.matched        <= 1'b1;
                r_out.slot_index     <= 2'(r_slot);
                r_out.angle          <= r_angle;
                r_out.speed_raw      <= r_speed;
                r_out.current_raw    <= r_current;
                r_out.turn_count     <= c_turns;
                r_out.total_position <= c_pos;
                r_out.home_angle     <= c_zero;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out.payload = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_accept) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        c_wr_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
            end
            S_READ: begin
            end
            S_UPDATE: begin
                c_wr_en = r_hit;
            end
            S_OUT: begin
                o_out.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: verif/motor_feedback_turn_tracker_top_tb.sv
// Self-checking testbench for the motor feedback turn tracker, with a scoreboard that unwraps turns.
`timescale 1ns / 1ps

module motor_feedback_turn_tracker_top_tb;
    import mftt_pkg::*;

    // Build of the block under test and the derived thresholds of the unwrapping.
    localparam int MOTOR_SLOTS = 4;
    localparam int ANGLE_MAX   = 8191;
    localparam int HALF_TURN   = ANGLE_MAX / 2;
    localparam int ENC_SPAN    = ANGLE_MAX + 1;

    // The last slot id register, and the highest index the port can carry at all.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LAST = CFG_SLOT0_ID + CFG_IDX_W'(MOTOR_SLOTS - 1);
    localparam int CFG_IDX_TOP = (1 << CFG_IDX_W) - 1;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES  = 250;
    localparam int RX_PHASE_LEN  = 300;

    // The receiver cycles through these ways of taking results.
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_BURSTY,
        RX_THIRDS
    } t_rx_mode;

    // Scoreboard: keeps its own copy of the slot table and the per-slot unwrap state,
    // predicts the feedback result of every accepted frame and checks results in order.
    class turn_unwrap_check;
        logic [2:0]  slot_count;
        logic [10:0] slot_id [MOTOR_SLOTS];
        logic [15:0] last_angle [MOTOR_SLOTS];
        logic [31:0] turns [MOTOR_SLOTS];
        bit          zero_seen [MOTOR_SLOTS];
        logic [15:0] home_angle [MOTOR_SLOTS];
        t_out_item   expected_feedback [$];
        int          errors;

        function new();
            slot_count = '0;
            errors     = 0;
            foreach (slot_id[k]) begin
                slot_id[k]    = '0;
                last_angle[k] = '0;
                turns[k]      = '0;
                zero_seen[k]  = 1'b0;
                home_angle[k] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_SLOTS_IN_USE) begin
                slot_count = data[2:0];
            end else if (index >= CFG_SLOT0_ID && index <= CFG_SLOT_LAST) begin
                slot_id[index - CFG_SLOT0_ID] = data;
            end
        endfunction

        function void note_frame(t_in_item f);
            t_out_item   e;
            logic [15:0] ang;
            int          searched;
            int          diff;
            e        = '0;
            ang      = {f.byte0, f.byte1};
            searched = (slot_count > MOTOR_SLOTS) ? MOTOR_SLOTS : int'(slot_count);
            for (int s = 0; s < searched; s++) begin
                if (!e.matched && slot_id[s] == f.frame_id) begin
                    diff = int'(last_angle[s]) - int'(ang);
                    if (diff > HALF_TURN) turns[s] = turns[s] + 1;
                    if (diff < -HALF_TURN) turns[s] = turns[s] - 1;
                    last_angle[s] = ang;
                    if (!zero_seen[s]) begin
                        zero_seen[s]  = 1'b1;
                        home_angle[s] = ang;
                    end
                    e.matched        = 1'b1;
                    e.slot_index     = 2'(s);
                    e.angle          = ang;
                    e.speed_raw      = {f.byte2, f.byte3};
                    e.current_raw    = {f.byte4, f.byte5};
                    e.turn_count     = turns[s];
                    e.total_position = (turns[s] << TURN_SHIFT) + {16'd0, ang};
                    e.home_angle     = home_angle[s];
                end
            end
            expected_feedback.push_back(e);
        endfunction

        function string show(t_out_item r);
            return $sformatf({"matched=%0b slot=%0d angle=%h speed=%h current=%h ",
                              "turns=%0d pos=%0d home=%h"},
                             r.matched, r.slot_index, r.angle, r.speed_raw, r.current_raw,
                             r.turn_count, r.total_position, r.home_angle);
        endfunction

        function void complain(string why, t_out_item want, t_out_item got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%t: %s", $realtime, why);
                $display("    expected %s", show(want));
                $display("    actual   %s", show(got));
            end
        endfunction

        function void check_feedback(t_out_item got);
            t_out_item want;
            bit        bad;
            if (expected_feedback.size() == 0) begin
                complain("result with no frame outstanding", '0, got);
                return;
            end
            want = expected_feedback.pop_front();
            bad  = (got.matched !== want.matched) || (got.slot_index !== want.slot_index) ||
                   (got.angle !== want.angle) || (got.speed_raw !== want.speed_raw) ||
                   (got.current_raw !== want.current_raw) ||
                   (got.turn_count !== want.turn_count) ||
                   (got.total_position !== want.total_position) ||
                   (got.home_angle !== want.home_angle);
            if (bad) complain("feedback result mismatch", want, got);
        endfunction

        function void finish_check();
            if (expected_feedback.size() != 0) begin
                errors += expected_feedback.size();
                $display("%0d frames never produced a result", expected_feedback.size());
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mftt_in_if  in_if();
    mftt_out_if out_if();
    mftt_cfg_if cfg_if();

    motor_feedback_turn_tracker_top #(
        .MOTOR_SLOTS(MOTOR_SLOTS),
        .ANGLE_MAX  (ANGLE_MAX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    turn_unwrap_check unwrap_chk = new();

    // Frames waiting to be offered, the slot ids of the next configuration, and a running
    // angle per slot so that most random frames move the shaft like a real motor would.
    t_in_item    frame_queue [$];
    logic [10:0] next_id [MOTOR_SLOTS] = '{default: '0};
    logic [15:0] walk_angle [MOTOR_SLOTS] = '{default: '0};
    int          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: the run is far shorter than this even with the slowest legal handshakes.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result side. Every accepted result is checked at the edge where it is taken, and the
    // ready line then follows a pattern that changes from phase to phase: free-running,
    // a coin toss per cycle, rare long stalls, and one cycle in three.
    initial begin : result_sink
        int rx_cycle;
        int hold;
        rx_cycle = 0;
        hold     = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) unwrap_chk.check_feedback(out_if.payload);
            rx_cycle++;
            case (t_rx_mode'((rx_cycle / RX_PHASE_LEN) % 4))
                RX_FREE: begin
                    out_if.ready <= 1'b1;
                end
                RX_COIN: begin
                    out_if.ready <= 1'($urandom_range(0, 1));
                end
                RX_BURSTY: begin
                    if (hold > 0) begin
                        hold--;
                        out_if.ready <= 1'b0;
                    end else begin
                        out_if.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 20);
                    end
                end
                default: begin
                    out_if.ready <= (rx_cycle % 3 == 0);
                end
            endcase
        end
    end

    // One register write. The valid line is left high so that writes can follow each other
    // without a gap; configure lowers it once the last write has gone through.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        t_cfg_write w;
        w.index = index;
        w.data  = data;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= w;
        do @(posedge i_clk); while (!cfg_if.ready);
        unwrap_chk.write_reg(index, data);
    endtask

    // Writes the slot count word, optionally all slot ids from next_id, and optionally junk
    // to the indexes beyond the last slot id, which the block must ignore. The junk goes last
    // so that a write wrongly aliased onto a real register shows up in the following frames.
    task automatic configure(input logic [CFG_DATA_W-1:0] count_word, input bit with_ids,
                             input bit with_stray);
        write_reg(CFG_SLOTS_IN_USE, count_word);
        if (with_ids) begin
            for (int k = 0; k < MOTOR_SLOTS; k++) write_reg(CFG_SLOT0_ID + CFG_IDX_W'(k), next_id[k]);
        end
        if (with_stray) begin
            for (int i = int'(CFG_SLOT_LAST) + 1; i <= CFG_IDX_TOP; i++) begin
                write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
            end
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Offers every queued frame in bursts of random length with random gaps between them,
    // then waits until every result has been taken so that the block is idle afterwards.
    // A gap of zero keeps valid high, so valid is never lowered and raised in one step.
    task automatic play_frames();
        t_in_item f;
        int       burst;
        int       gap;
        while (frame_queue.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && frame_queue.size() > 0) begin
                f = frame_queue.pop_front();
                in_if.valid   <= 1'b1;
                in_if.payload <= f;
                do @(posedge i_clk); while (!in_if.ready);
                unwrap_chk.note_frame(f);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (unwrap_chk.expected_feedback.size() != 0);
    endtask

    function automatic t_in_item feedback_frame(logic [10:0] id, logic [15:0] ang,
                                                logic [15:0] speed, logic [15:0] current);
        t_in_item f;
        f.frame_id = id;
        {f.byte0, f.byte1} = ang;
        {f.byte2, f.byte3} = speed;
        {f.byte4, f.byte5} = current;
        return f;
    endfunction

    // Most random frames address a searched slot and step its angle by a plausible amount,
    // some of them right at the half-turn threshold; the rest are unsearched slots, stray
    // ids and angles anywhere in the 16-bit word.
    function automatic t_in_item random_frame();
        int          searched;
        int          roll;
        int          k;
        int          ang;
        logic [15:0] a16;
        logic [10:0] id;
        searched = (unwrap_chk.slot_count > MOTOR_SLOTS) ? MOTOR_SLOTS : int'(unwrap_chk.slot_count);
        roll     = $urandom_range(0, 99);
        if (roll < 80 && searched > 0) k = $urandom_range(0, searched - 1);
        else k = $urandom_range(0, MOTOR_SLOTS - 1);
        id = (roll >= 92) ? 11'($urandom) : unwrap_chk.slot_id[k];
        case ($urandom_range(0, 9))
            0: ang = $urandom_range(0, 16'hFFFF);
            1: ang = $urandom_range(0, ANGLE_MAX);
            2: begin
                ang = int'(walk_angle[k]) + HALF_TURN + int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1) ang = 2 * int'(walk_angle[k]) - ang;
                ang = ((ang % ENC_SPAN) + ENC_SPAN) % ENC_SPAN;
            end
            default: begin
                ang = int'(walk_angle[k]) + int'($urandom_range(0, 6000)) - 3000;
                ang = ((ang % ENC_SPAN) + ENC_SPAN) % ENC_SPAN;
            end
        endcase
        a16 = 16'(ang);
        walk_angle[k] = a16;
        return feedback_frame(id, a16, 16'($urandom), 16'($urandom));
    endfunction

    initial begin : stimulus
        int roll;
        logic [2:0] count;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.payload  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset no slot is searched, so even an id equal to the reset id of
        // slot 0 must come back unmatched with every field zero.
        frame_queue.push_back(feedback_frame(11'h000, 16'h1234, 16'h0001, 16'h8000));
        play_frames();

        // A slot count above the table size (all data bits set) searches all four slots.
        // Slot 3 repeats the id of slot 0, so only slot 0 may ever be updated for it.
        next_id = '{11'h7FF, 11'h000, 11'h201, 11'h7FF};
        configure(11'h7FF, 1'b1, 1'b1);

        // Slot 0: the first frame latches its zero angle, then a fall and a rise of more
        // than half a turn take the count down and back up.
        frame_queue.push_back(feedback_frame(11'h7FF, 16'h0ABC, 16'h0000, 16'h0000));
        frame_queue.push_back(feedback_frame(11'h7FF, 16'h1FFF, 16'hFFFF, 16'hFFFF));
        frame_queue.push_back(feedback_frame(11'h7FF, 16'h0000, 16'h0000, 16'hFFFF));
        // Slot 1: its first frame is unwrapped against an angle of zero, then the steps sit
        // exactly on and just past the half-turn threshold in both directions.
        frame_queue.push_back(feedback_frame(11'h000, 16'h1FFF, 16'h7FFF, 16'h8000));
        frame_queue.push_back(feedback_frame(11'h000, 16'h1000, 16'h8000, 16'h7FFF));
        frame_queue.push_back(feedback_frame(11'h000, 16'h0000, 16'h0001, 16'hFFFE));
        frame_queue.push_back(feedback_frame(11'h000, 16'h0FFF, 16'h1234, 16'h5678));
        frame_queue.push_back(feedback_frame(11'h000, 16'h1FFF, 16'h9ABC, 16'hDEF0));
        // Slot 2: angles beyond the encoder range, with the full word at its extremes.
        frame_queue.push_back(feedback_frame(11'h201, 16'hFFFF, 16'h8000, 16'h7FFF));
        frame_queue.push_back(feedback_frame(11'h201, 16'h0000, 16'hFFFF, 16'h0000));
        // An id that no slot holds, then a patterned frame for slot 0.
        frame_queue.push_back(feedback_frame(11'h123, 16'h5A5A, 16'hA5A5, 16'hC3C3));
        frame_queue.push_back(feedback_frame(11'h7FF, 16'hAA55, 16'h55AA, 16'hA5A5));
        play_frames();

        // With two slots searched the id of slot 2 no longer matches.
        configure(CFG_DATA_W'(2), 1'b0, 1'b0);
        frame_queue.push_back(feedback_frame(11'h201, 16'h0100, 16'h0001, 16'h0002));
        frame_queue.push_back(feedback_frame(11'h000, 16'h0200, 16'h0003, 16'h0004));
        frame_queue.push_back(feedback_frame(11'h7FF, 16'h0300, 16'h0005, 16'h0006));
        play_frames();

        configure(CFG_DATA_W'(1), 1'b0, 1'b0);
        frame_queue.push_back(feedback_frame(11'h000, 16'h0400, 16'h0007, 16'h0008));
        frame_queue.push_back(feedback_frame(11'h7FF, 16'h1F00, 16'h0009, 16'h000A));
        play_frames();

        configure('0, 1'b0, 1'b0);
        frame_queue.push_back(feedback_frame(11'h7FF, 16'h0000, 16'hFFFF, 16'hFFFF));
        play_frames();

        // Random phases, each with a fresh slot table: mostly one to four slots, sometimes
        // none or more than the table holds, and now and then a duplicated id.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) count = '0;
            else if (roll == 1) count = 3'($urandom_range(MOTOR_SLOTS + 1, 7));
            else count = 3'($urandom_range(1, MOTOR_SLOTS));
            for (int k = 0; k < MOTOR_SLOTS; k++) begin
                if (k > 0 && $urandom_range(0, 4) == 0) next_id[k] = next_id[$urandom_range(0, k - 1)];
                else next_id[k] = 11'($urandom);
            end
            configure({8'($urandom), count}, 1'b1, 1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_FRAMES; n++) frame_queue.push_back(random_frame());
            play_frames();
        end

        // Give any spurious late result time to appear before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        unwrap_chk.finish_check();
        if (unwrap_chk.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
